// ===== hw/rtl/tlr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_pkg: shared types and constants for the telnet line receiver
// Event codes, terminal table and the word passed from front to back.
// ----------------------------------------------------------------------------
package tlr_pkg;

  localparam int LINE_BUFFER_DEF = 256;
  localparam int TTYPE_CHARS_DEF = 16;
  localparam int NTERMS = 13;

  localparam logic [2:0] EV_NONE   = 3'd0;
  localparam logic [2:0] EV_EC     = 3'd1;
  localparam logic [2:0] EV_EL     = 3'd2;
  localparam logic [2:0] EV_IP     = 3'd3;
  localparam logic [2:0] EV_TTREQ  = 3'd4;
  localparam logic [2:0] EV_EOR    = 3'd5;
  localparam logic [2:0] EV_SIZE   = 3'd6;
  localparam logic [2:0] EV_TTRECV = 3'd7;

  localparam logic [1:0] REG_DWIDTH = 2'd0;
  localparam logic [1:0] REG_DLINES = 2'd1;
  localparam logic [1:0] REG_DGA    = 2'd2;
  localparam logic [1:0] REG_PWD    = 2'd3;

  localparam logic [7:0] C_IAC = 8'd255;
  localparam logic [7:0] C_SB  = 8'd250;
  localparam logic [7:0] C_WILL = 8'd251;
  localparam logic [7:0] C_WONT = 8'd252;
  localparam logic [7:0] C_DO  = 8'd253;
  localparam logic [7:0] C_DONT = 8'd254;
  localparam logic [7:0] C_EC  = 8'd247;
  localparam logic [7:0] C_EL  = 8'd248;
  localparam logic [7:0] C_IP  = 8'd244;
  localparam logic [7:0] C_TTYPE = 8'd24;
  localparam logic [7:0] C_NAWS = 8'd31;
  localparam logic [7:0] C_ECHO = 8'd1;
  localparam logic [7:0] C_EORO = 8'd25;
  localparam logic [7:0] C_LF  = 8'd10;
  localparam logic [7:0] C_CR  = 8'd13;
  localparam logic [7:0] C_BS  = 8'd8;
  localparam logic [7:0] C_DEL = 8'd127;

  // result of one classified byte, front to back
  typedef struct packed {
    logic       char_valid;
    logic [7:0] char_byte;
    logic       echo;
    logic       line_ready;
    logic [7:0] line_length;
    logic [2:0] event_res;
    logic [3:0] term_code;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic [1:0] size_detected;
    logic [2:0] mode_flags;
  } tlr_word_t;

  function automatic int term_len(input int e);
    case (e)
      0, 5: term_len = 3;
      1: term_len = 4;
      4, 7, 8, 9, 11: term_len = 5;
      12: term_len = 7;
      default: term_len = 6;
    endcase
  endfunction

  function automatic logic [7:0] term_char(input int e, input int p);
    logic [55:0] s;
    case (e)
      0: s = "adm";
      1: s = "ansi";
      2: s = "cygwin";
      3: s = "hp2392";
      4: s = "linux";
      5: s = "sun";
      6: s = "tvi912";
      7: s = "vt100";
      8: s = "vt102";
      9: s = "vt220";
      10: s = "wyse30";
      11: s = "xterm";
      default: s = "unknown";
    endcase
    if (p >= term_len(e)) term_char = 8'd0;
    else term_char = s[8*(term_len(e)-1-p) +: 8];
  endfunction

  function automatic logic [3:0] term_cd(input int e);
    case (e)
      0: term_cd = 4'd1;
      1, 2, 4: term_cd = 4'd2;
      3: term_cd = 4'd3;
      5: term_cd = 4'd4;
      6: term_cd = 4'd5;
      7: term_cd = 4'd6;
      8: term_cd = 4'd7;
      9: term_cd = 4'd8;
      10: term_cd = 4'd9;
      11: term_cd = 4'd10;
      default: term_cd = 4'd0;
    endcase
  endfunction

  function automatic logic [7:0] lower8(input logic [7:0] c);
    lower8 = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

// ===== hw/rtl/tlr_stream_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_stream_if: valid/ready channel
// Carries one payload word per handshake.
// ----------------------------------------------------------------------------
interface tlr_stream_if #(parameter type payload_t = logic [7:0]);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/tlr_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_cfg_if: configuration write channel
// Register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface tlr_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== hw/rtl/tlr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_front: byte parser
// Holds all parser state and classifies one byte per cycle, when in_fire accepts it, into a result word.
// ----------------------------------------------------------------------------
module tlr_front import tlr_pkg::*; #(
  parameter int LINE_BUFFER = LINE_BUFFER_DEF,
  parameter int TTYPE_CHARS = TTYPE_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  input  logic        cfg_fire,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  output tlr_word_t   word
);

  localparam int LW = $clog2(TTYPE_CHARS + 1);
  localparam int PW = $clog2(TTYPE_CHARS);
  localparam logic [7:0] LINE_MAX = 8'((LINE_BUFFER - 3 > 255) ? 255 : LINE_BUFFER - 3);

  typedef enum logic [3:0] {
    PH_DATA, PH_IAC, PH_SB, PH_TTQUAL, PH_TTNAME, PH_TTSE, PH_NAWS,
    PH_NAWSSE1, PH_NAWSSE2, PH_WILL, PH_WONT, PH_DO, PH_DONT
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic [15:0] dw_r, dl_r;
  logic dga_r, pwd_r;
  logic [7:0] idx_r, idx_nxt;
  logic cr_r, cr_nxt, lf_r, lf_nxt;
  logic [1:0] ncnt_r, ncnt_nxt;
  logic nesc_r, nesc_nxt;
  logic [15:0] nw_r, nw_nxt, nl_r, nl_nxt;
  logic [LW-1:0] nlen_r, nlen_nxt, plen_r, plen_nxt;
  logic nclosed_r, nclosed_nxt;
  logic [NTERMS-1:0] tmv_r, tmv_nxt;
  logic [TTYPE_CHARS-1:0] same_r, same_nxt;
  logic [7:0] nbuf_r [TTYPE_CHARS];
  logic [7:0] prev_r [TTYPE_CHARS];
  logic [3:0] tt_r, tt_nxt;
  logic tdet_r, tdet_nxt;
  logic [15:0] wr_r, wr_nxt, lr_r, lr_nxt;
  logic [1:0] df_r, df_nxt;
  logic [2:0] md_r, md_nxt;
  logic nwrite, pcopy;
  logic [7:0] c;
  logic [15:0] wm, lm;
  logic hit;
  logic ended;
  tlr_word_t w;

  assign c = in_byte;

  always_comb begin
    phase_nxt = phase_r; idx_nxt = idx_r; cr_nxt = cr_r; lf_nxt = lf_r;
    ncnt_nxt = ncnt_r; nesc_nxt = nesc_r; nw_nxt = nw_r; nl_nxt = nl_r;
    nlen_nxt = nlen_r; plen_nxt = plen_r; nclosed_nxt = nclosed_r; tmv_nxt = tmv_r;
    same_nxt = same_r; tt_nxt = tt_r; tdet_nxt = tdet_r; wr_nxt = wr_r; lr_nxt = lr_r;
    df_nxt = df_r; md_nxt = md_r; nwrite = 1'b0; pcopy = 1'b0; ended = 1'b0; hit = 1'b0;
    wm = 16'd0; lm = 16'd0;
    w = '0;
    case (phase_r)
      PH_IAC: begin
        phase_nxt = PH_DATA;
        case (c)
          C_SB: phase_nxt = PH_SB;
          C_WILL: phase_nxt = PH_WILL;
          C_WONT: phase_nxt = PH_WONT;
          C_DO: phase_nxt = PH_DO;
          C_DONT: phase_nxt = PH_DONT;
          C_EC: begin
            if (idx_r != 8'd0) idx_nxt = idx_r - 8'd1;
            w.event_res = EV_EC;
          end
          C_EL: begin idx_nxt = 8'd0; w.event_res = EV_EL; end
          C_IP: w.event_res = EV_IP;
          default: ;
        endcase
      end
      PH_SB: begin
        if (c == C_TTYPE) phase_nxt = PH_TTQUAL;
        else if (c == C_NAWS) begin
          phase_nxt = PH_NAWS; ncnt_nxt = 2'd0; nesc_nxt = 1'b0;
          nw_nxt = 16'd0; nl_nxt = 16'd0;
        end else phase_nxt = PH_DATA;
      end
      PH_TTQUAL: begin
        if (c == 8'd0) begin
          phase_nxt = PH_TTNAME; nlen_nxt = '0; nclosed_nxt = 1'b0;
          tmv_nxt = '1; same_nxt = '1;
        end else phase_nxt = PH_DATA;
      end
      PH_TTNAME: begin
        if (c == C_IAC) begin
          phase_nxt = PH_TTSE;
          w.event_res = EV_TTRECV;
          for (int e = NTERMS - 1; e >= 0; e--) begin
            if (tmv_r[e] && nlen_r == LW'(term_len(e))) begin
              hit = 1'b1; tt_nxt = term_cd(e);
            end
          end
          if (hit) tdet_nxt = 1'b1;
          else if (!tdet_r) begin
            if (!(plen_r == nlen_r && &same_r)) w.event_res = EV_TTREQ;
            pcopy = 1'b1; plen_nxt = nlen_r;
          end
        end else if (!nclosed_r && nlen_r < LW'(TTYPE_CHARS)) begin
          if (c == 8'd0) nclosed_nxt = 1'b1;
          else begin
            for (int e = 0; e < NTERMS; e++)
              if (nlen_r >= LW'(term_len(e)) || lower8(c) != term_char(e, int'(nlen_r)))
                tmv_nxt[e] = 1'b0;
            for (int i = 0; i < TTYPE_CHARS; i++)
              if (nlen_r == LW'(i) && lower8(c) != lower8(prev_r[i])) same_nxt[i] = 1'b0;
            nwrite = 1'b1;
            nlen_nxt = nlen_r + LW'(1);
          end
        end
      end
      PH_TTSE: phase_nxt = PH_DATA;
      PH_NAWS: begin
        if (!nesc_r && c == C_IAC) nesc_nxt = 1'b1;
        else begin
          nesc_nxt = 1'b0;
          case (ncnt_r)
            2'd0: nw_nxt[15:8] = c;
            2'd1: nw_nxt[7:0] = c;
            2'd2: nl_nxt[15:8] = c;
            default: nl_nxt[7:0] = c;
          endcase
          if (ncnt_r == 2'd3) phase_nxt = PH_NAWSSE1;
          ncnt_nxt = ncnt_r + 2'd1;
        end
      end
      PH_NAWSSE1: phase_nxt = PH_NAWSSE2;
      PH_NAWSSE2: begin
        w.event_res = EV_SIZE; phase_nxt = PH_DATA;
        wm = nw_r - 16'd1; lm = nl_r - 16'd1;
        if (nw_r == 16'd0) wr_nxt = dw_r;
        else if (nw_r == 16'd1) begin wr_nxt = dw_r; df_nxt[0] = 1'b0; end
        else begin wr_nxt = wm; df_nxt[0] = 1'b1; end
        if (nl_r == 16'd0) lr_nxt = dl_r;
        else if (nl_r == 16'd1) begin lr_nxt = dl_r; df_nxt[1] = 1'b0; end
        else begin lr_nxt = lm; df_nxt[1] = 1'b1; end
        // a zero width or height with default below one also clears its flag
        if (nw_r == 16'd0 && dw_r == 16'd0) df_nxt[0] = 1'b0;
        if (nl_r == 16'd0 && dl_r == 16'd0) df_nxt[1] = 1'b0;
      end
      PH_WILL: begin
        if (c == C_TTYPE) w.event_res = EV_TTREQ;
        phase_nxt = PH_DATA;
      end
      PH_WONT: phase_nxt = PH_DATA;
      PH_DO: begin
        if (c == C_ECHO) md_nxt[0] = 1'b1;
        else if (c == C_EORO) begin
          md_nxt[1] = 1'b1; md_nxt[2] = 1'b0; w.event_res = EV_EOR;
        end
        phase_nxt = PH_DATA;
      end
      PH_DONT: begin
        if (c == C_ECHO) md_nxt[0] = 1'b0;
        else if (c == C_EORO) begin
          md_nxt[1] = 1'b0; if (dga_r) md_nxt[2] = 1'b1;
        end
        phase_nxt = PH_DATA;
      end
      default: begin
        phase_nxt = PH_DATA;
        if (c == C_IAC) begin
          cr_nxt = 1'b0; lf_nxt = 1'b0; phase_nxt = PH_IAC;
        end else if (c == C_LF) begin
          if (!cr_r) begin lf_nxt = 1'b1; ended = 1'b1; end
        end else if (c == C_CR) begin
          if (!lf_r) begin cr_nxt = 1'b1; ended = 1'b1; end
        end else begin
          cr_nxt = 1'b0; lf_nxt = 1'b0;
          if (c == C_BS || c == C_DEL || c == C_EC) begin
            if (idx_r != 8'd0) idx_nxt = idx_r - 8'd1;
            w.event_res = EV_EC;
          end else if (c > 8'd31 && c < 8'd128 && idx_r < LINE_MAX) begin
            w.char_byte = c; w.char_valid = 1'b1; idx_nxt = idx_r + 8'd1;
            w.echo = md_r[0] && !pwd_r;
          end
        end
      end
    endcase
    w.line_length = idx_nxt;
    if (ended) begin
      w.line_ready = 1'b1; w.line_length = idx_r; idx_nxt = 8'd0;
    end
    w.term_code = tt_nxt;
    w.win_width = wr_nxt;
    w.win_height = lr_nxt;
    w.size_detected = df_nxt;
    w.mode_flags = md_nxt;
  end

  assign word = w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_r <= 16'd80; dl_r <= 16'd24; dga_r <= 1'b1; pwd_r <= 1'b0;
    end else if (cfg_fire) begin
      case (cfg_idx)
        REG_DWIDTH: dw_r <= cfg_data;
        REG_DLINES: dl_r <= cfg_data;
        REG_DGA: dga_r <= cfg_data[0];
        REG_PWD: pwd_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DATA; idx_r <= '0; cr_r <= 1'b0; lf_r <= 1'b0;
      ncnt_r <= '0; nesc_r <= 1'b0; nw_r <= '0; nl_r <= '0;
      nlen_r <= '0; plen_r <= '0; nclosed_r <= 1'b0; tmv_r <= '1; same_r <= '1;
      tt_r <= '0; tdet_r <= 1'b0; wr_r <= 16'd80; lr_r <= 16'd24;
      df_r <= '0; md_r <= '0;
      for (int i = 0; i < TTYPE_CHARS; i++) prev_r[i] <= 8'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt; idx_r <= idx_nxt; cr_r <= cr_nxt; lf_r <= lf_nxt;
      ncnt_r <= ncnt_nxt; nesc_r <= nesc_nxt; nw_r <= nw_nxt; nl_r <= nl_nxt;
      nlen_r <= nlen_nxt; plen_r <= plen_nxt; nclosed_r <= nclosed_nxt;
      tmv_r <= tmv_nxt; same_r <= same_nxt; tt_r <= tt_nxt; tdet_r <= tdet_nxt;
      wr_r <= wr_nxt; lr_r <= lr_nxt; df_r <= df_nxt; md_r <= md_nxt;
      if (pcopy)
        for (int i = 0; i < TTYPE_CHARS; i++)
          if (LW'(i) < nlen_r) prev_r[i] <= nbuf_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && nwrite) nbuf_r[nlen_r[PW-1:0]] <= c;
  end

endmodule

// ===== hw/rtl/tlr_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlr_queue: two-entry result queue
// Decouples the parser from the output channel; full rate until output stalls fill it.
// ----------------------------------------------------------------------------
module tlr_queue import tlr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  tlr_word_t push_data,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output tlr_word_t out_data
);

  tlr_word_t mem_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;
  logic pop;

  assign pop = out_valid && out_ready;
  assign can_push = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);
  assign out_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != 2'd0) else $error("queue underflow");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");

endmodule

// ===== hw/rtl/telnet_line_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telnet_line_receiver_top: telnet receive parser
// Byte in, one result word out per byte.
// ----------------------------------------------------------------------------
// Channels: in (rx_byte), out (result word), cfg (index 0..3, 16-bit data).
// Every accepted byte yields exactly one result word, in order.
// Latency: the word is queued at the accept edge and, from an empty queue,
// is visible on out the next cycle. Throughput: one byte per cycle while out
// keeps up, set by the combinational parser step feeding a two-entry queue.
// When out stalls, the queue fills and in_ready drops after two words; it
// rises again the cycle after a word is taken.
// Reset (rst_n low, synchronous) clears the parser to plain data, the
// defaults to 80 by 24 with go-ahead on and password mode off, and
// empties the queue. cfg is always ready and should be written while idle.
// ----------------------------------------------------------------------------
module telnet_line_receiver_top import tlr_pkg::*; #(
  parameter int LINE_BUFFER = LINE_BUFFER_DEF,
  parameter int TTYPE_CHARS = TTYPE_CHARS_DEF
) (
  input logic clk,
  input logic rst_n,
  tlr_stream_if.sink   in_ch,
  tlr_stream_if.source out_ch,
  tlr_cfg_if.sink      cfg_ch
);

  logic in_fire, can_push;
  tlr_word_t word;

  assign in_ch.ready = can_push;
  assign in_fire = in_ch.valid && can_push;
  assign cfg_ch.ready = 1'b1;

  tlr_front #(.LINE_BUFFER(LINE_BUFFER), .TTYPE_CHARS(TTYPE_CHARS)) u_front (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_byte(in_ch.data),
    .cfg_fire(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.wdata),
    .word(word)
  );

  tlr_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(in_fire), .push_data(word),
    .can_push(can_push), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
  );

endmodule

// ===== tb/sv/tb_telnet_line_receiver_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_telnet_line_receiver_top: self-checking bench for the telnet receiver
// Feeds received bytes (plain text, line ends, erase codes, IAC commands,
// NAWS and TTYPE subnegotiations, noise) under random stalls on both sides.
// Each result word is checked against a behavioral parser model or a typed
// table word; defaults and password mode change between phases while idle.
// ----------------------------------------------------------------------------
module tb_telnet_line_receiver_top;
  import tlr_pkg::*;

  localparam int LIMIT = 400000;
  localparam int LINE_MAX = LINE_BUFFER_DEF - 3;
  localparam logic [7:0] C_SE = 8'd240;

  typedef enum logic [3:0] {
    P_DATA, P_IAC, P_SB, P_TTQUAL, P_TTNAME, P_TTSE, P_NAWS, P_NAWSSE1,
    P_NAWSSE2, P_WILL, P_WONT, P_DO, P_DONT
  } rx_phase_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    tlr_word_t  w;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tlr_stream_if #(.payload_t(logic [7:0])) in_ch();
  tlr_stream_if #(.payload_t(tlr_word_t))  out_ch();
  tlr_cfg_if cfg_ch();

  telnet_line_receiver_top u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  initial forever #1 clk = ~clk;

  // model state
  logic [15:0] dflt_width = 16'd80, dflt_lines = 16'd24;
  logic        dflt_ga = 1'b1, pwd_on = 1'b0;
  logic [7:0]  idx;
  logic        cr_seen, lf_seen;
  rx_phase_t   phase;
  logic [2:0]  naws_cnt;
  logic        naws_esc;
  logic [15:0] naws_w, naws_l;
  logic [4:0]  nm_len, prev_len;
  logic        nm_closed;
  logic [12:0] match_vec;
  logic [7:0]  nm_buf[16], prev_nm[16];
  logic [3:0]  term_reg;
  logic        type_found;
  logic [15:0] width_r, lines_r;
  logic [1:0]  det_r;
  logic [2:0]  mode_r;

  string    term_txt[13] = '{"adm", "ansi", "cygwin", "hp2392", "linux", "sun",
                             "tvi912", "vt100", "vt102", "vt220", "wyse30", "xterm",
                             "unknown"};
  int       term_num[13] = '{1, 2, 2, 3, 2, 4, 5, 6, 7, 8, 9, 10, 0};

  tlr_word_t   exp_words[$];
  logic [7:0]  rx_bytes[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  int          out_stall = 0, out_run = 0;

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic void model_reset();
    idx = 0; cr_seen = 0; lf_seen = 0; phase = P_DATA;
    naws_cnt = 0; naws_esc = 0; naws_w = 0; naws_l = 0;
    nm_len = 0; nm_closed = 0; match_vec = '1; prev_len = 0;
    foreach (prev_nm[i]) prev_nm[i] = 0;
    term_reg = 0; type_found = 0; width_r = 80; lines_r = 24; det_r = 0; mode_r = 0;
  endfunction

  function automatic logic [2:0] finish_name();
    bit same;
    for (int e = 0; e < 13; e++)
      if (match_vec[e] && term_txt[e].len() == nm_len) begin
        term_reg = 4'(term_num[e]);
        type_found = 1;
        return EV_TTRECV;
      end
    if (type_found) return EV_TTRECV;
    same = (prev_len == nm_len);
    for (int i = 0; same && i < nm_len; i++)
      if (to_lower(prev_nm[i]) != to_lower(nm_buf[i])) same = 0;
    for (int i = 0; i < nm_len; i++) prev_nm[i] = nm_buf[i];
    prev_len = nm_len;
    return same ? EV_TTRECV : EV_TTREQ;
  endfunction

  function automatic tlr_word_t rx_predict(logic [7:0] c);
    tlr_word_t w;
    bit ended;
    int p;
    w = '0;
    ended = 0;
    case (phase)
      P_IAC: begin
        phase = P_DATA;
        if (c == C_SB) phase = P_SB;
        else if (c == C_WILL) phase = P_WILL;
        else if (c == C_WONT) phase = P_WONT;
        else if (c == C_DO) phase = P_DO;
        else if (c == C_DONT) phase = P_DONT;
        else if (c == C_EC) begin
          if (idx > 0) idx--;
          w.event_res = EV_EC;
        end else if (c == C_EL) begin
          idx = 0;
          w.event_res = EV_EL;
        end else if (c == C_IP) w.event_res = EV_IP;
      end
      P_SB: begin
        if (c == C_TTYPE) phase = P_TTQUAL;
        else if (c == C_NAWS) begin
          phase = P_NAWS; naws_cnt = 0; naws_esc = 0; naws_w = 0; naws_l = 0;
        end else phase = P_DATA;
      end
      P_TTQUAL: begin
        if (c == 0) begin
          phase = P_TTNAME; nm_len = 0; nm_closed = 0; match_vec = '1;
        end else phase = P_DATA;
      end
      P_TTNAME: begin
        if (c == C_IAC) begin
          w.event_res = finish_name();
          phase = P_TTSE;
        end else if (!nm_closed && nm_len < TTYPE_CHARS_DEF) begin
          if (c == 0) nm_closed = 1;
          else begin
            p = nm_len;
            for (int e = 0; e < 13; e++)
              if (p >= term_txt[e].len() || to_lower(c) != term_txt[e][p])
                match_vec[e] = 0;
            nm_buf[p] = c;
            nm_len = 5'(p + 1);
          end
        end
      end
      P_TTSE: phase = P_DATA;
      P_NAWS: begin
        if (!naws_esc && c == C_IAC) naws_esc = 1;
        else begin
          naws_esc = 0;
          case (naws_cnt[1:0])
            2'd0: naws_w[15:8] = c;
            2'd1: naws_w[7:0] = c;
            2'd2: naws_l[15:8] = c;
            default: naws_l[7:0] = c;
          endcase
          if (naws_cnt >= 3) begin
            naws_cnt = 0; phase = P_NAWSSE1;
          end else naws_cnt++;
        end
      end
      P_NAWSSE1: phase = P_NAWSSE2;
      P_NAWSSE2: begin
        if (naws_w == 0) width_r = dflt_width;
        else begin
          width_r = naws_w - 16'd1; det_r[0] = 1;
        end
        if (naws_l == 0) lines_r = dflt_lines;
        else begin
          lines_r = naws_l - 16'd1; det_r[1] = 1;
        end
        if (width_r < 1) begin
          width_r = dflt_width; det_r[0] = 0;
        end
        if (lines_r < 1) begin
          lines_r = dflt_lines; det_r[1] = 0;
        end
        w.event_res = EV_SIZE;
        phase = P_DATA;
      end
      P_WILL: begin
        if (c == C_TTYPE) w.event_res = EV_TTREQ;
        phase = P_DATA;
      end
      P_WONT: phase = P_DATA;
      P_DO: begin
        if (c == C_ECHO) mode_r[0] = 1;
        else if (c == C_EORO) begin
          mode_r[1] = 1; mode_r[2] = 0; w.event_res = EV_EOR;
        end
        phase = P_DATA;
      end
      P_DONT: begin
        if (c == C_ECHO) mode_r[0] = 0;
        else if (c == C_EORO) begin
          mode_r[1] = 0;
          if (dflt_ga) mode_r[2] = 1;
        end
        phase = P_DATA;
      end
      default: begin
        phase = P_DATA;
        if (c == C_IAC) begin
          cr_seen = 0; lf_seen = 0; phase = P_IAC;
        end else if (c == C_LF) begin
          if (!cr_seen) begin
            lf_seen = 1; ended = 1;
          end
        end else if (c == C_CR) begin
          if (!lf_seen) begin
            cr_seen = 1; ended = 1;
          end
        end else begin
          cr_seen = 0; lf_seen = 0;
          if (c == C_BS || c == C_DEL || c == C_EC) begin
            if (idx > 0) idx--;
            w.event_res = EV_EC;
          end else if (c > 31 && c < 128 && idx < LINE_MAX) begin
            w.char_byte = c; idx++; w.char_valid = 1;
            w.echo = mode_r[0] && !pwd_on;
          end
        end
      end
    endcase
    w.line_length = idx;
    if (ended) begin
      w.line_ready = 1; idx = 0;
    end
    w.term_code = term_reg; w.win_width = width_r; w.win_height = lines_r;
    w.size_detected = det_r; w.mode_flags = mode_r;
    return w;
  endfunction

  task automatic send_byte(logic [7:0] b, bit typed = 0, tlr_word_t tw = '0);
    tlr_word_t pw;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= b;
    do @(posedge clk); while (!in_ch.ready);
    pw = rx_predict(b);
    exp_words.push_back(typed ? tw : pw);
  endtask

  // valid stays high between back-to-back writes; caller drops it after the last
  task automatic write_reg(logic [1:0] ri, logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= ri;
    cfg_ch.wdata <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    case (ri)
      REG_DWIDTH: dflt_width = v;
      REG_DLINES: dflt_lines = v;
      REG_DGA:    dflt_ga = v[0];
      default:    pwd_on = v[0];
    endcase
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (exp_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_naws_val(logic [15:0] v);
    rx_bytes.push_back(v[15:8]);
    if (v[15:8] == C_IAC) rx_bytes.push_back(C_IAC);
    rx_bytes.push_back(v[7:0]);
    if (v[7:0] == C_IAC) rx_bytes.push_back(C_IAC);
  endfunction

  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd1;
      2: return 16'd2;
      3: return 16'hFFFF;
      4: return {8'hFF, 8'($urandom_range(0, 255))};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic void gen_seq();
    int n, e;
    string s;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1: begin
        n = $urandom_range(1, 12);
        repeat (n) rx_bytes.push_back(8'($urandom_range(32, 126)));
        case ($urandom_range(0, 3))
          0: rx_bytes.push_back(C_CR);
          1: rx_bytes.push_back(C_LF);
          2: begin rx_bytes.push_back(C_CR); rx_bytes.push_back(C_LF); end
          default: begin rx_bytes.push_back(C_LF); rx_bytes.push_back(C_CR); end
        endcase
      end
      2: begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: rx_bytes.push_back(C_BS);
            1: rx_bytes.push_back(C_DEL);
            2: rx_bytes.push_back(C_EC);
            default: rx_bytes.push_back(8'($urandom_range(0, 31)));
          endcase
        end
      end
      3: begin
        rx_bytes.push_back(C_IAC);
        case ($urandom_range(0, 5))
          0: rx_bytes.push_back(C_EC);
          1: rx_bytes.push_back(C_EL);
          2: rx_bytes.push_back(C_IP);
          3: rx_bytes.push_back(8'($urandom_range(0, 249)));
          default: begin
            rx_bytes.push_back(8'($urandom_range(C_WILL, C_DONT)));
            case ($urandom_range(0, 3))
              0: rx_bytes.push_back(C_ECHO);
              1: rx_bytes.push_back(C_EORO);
              2: rx_bytes.push_back(C_TTYPE);
              default: rx_bytes.push_back(8'($urandom));
            endcase
          end
        endcase
      end
      4, 5: begin
        rx_bytes.push_back(C_IAC); rx_bytes.push_back(C_SB); rx_bytes.push_back(C_NAWS);
        push_naws_val(pick_size());
        push_naws_val(pick_size());
        rx_bytes.push_back(C_IAC); rx_bytes.push_back(C_SE);
      end
      6, 7: begin
        rx_bytes.push_back(C_IAC); rx_bytes.push_back(C_SB); rx_bytes.push_back(C_TTYPE);
        rx_bytes.push_back($urandom_range(0, 9) == 0 ? 8'd1 : 8'd0);
        case ($urandom_range(0, 3))
          0, 1: begin
            e = $urandom_range(0, 12);
            s = term_txt[e];
            for (int i = 0; i < s.len(); i++) begin
              c = s[i];
              if ($urandom_range(0, 1) && c >= "a" && c <= "z") c = c - 8'd32;
              rx_bytes.push_back(c);
            end
            if ($urandom_range(0, 4) == 0) rx_bytes.push_back(8'($urandom_range(97, 122)));
          end
          2: begin
            n = $urandom_range(1, 6);
            repeat (n) rx_bytes.push_back(8'($urandom_range(97, 122)));
          end
          default: begin
            n = $urandom_range(15, 20);
            repeat (n) rx_bytes.push_back(8'($urandom_range(1, 254)));
            if ($urandom_range(0, 1)) begin
              rx_bytes.push_back(8'd0); rx_bytes.push_back(8'd65);
            end
          end
        endcase
        rx_bytes.push_back(C_IAC); rx_bytes.push_back(C_SE);
      end
      8: begin
        rx_bytes.push_back(C_IAC); rx_bytes.push_back(C_SB);
        rx_bytes.push_back(8'($urandom_range(32, 254)));
      end
      default: rx_bytes.push_back(8'($urandom));
    endcase
  endfunction

  // result side
  always @(posedge clk) begin
    tlr_word_t want;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (exp_words.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word %p", out_ch.data);
        end else begin
          want = exp_words.pop_front();
          if (out_ch.data !== want) begin
            errors++;
            if (errors <= 10) $display("mismatch: expected %p got %p", want, out_ch.data);
          end
        end
      end
      if (out_stall > 0) begin
        out_stall <= out_stall - 1;
        out_ch.ready <= 1'b0;
      end else if (!quiet && out_run == 0 && $urandom_range(0, 5) == 0) begin
        out_stall <= $urandom_range(0, 15);
        out_run <= $urandom_range(0, 40);
        out_ch.ready <= 1'b0;
      end else begin
        if (out_run > 0) out_run <= out_run - 1;
        out_ch.ready <= 1'b1;
      end
    end
  end

  dir_row_t dir_tab[$];

  initial begin
    tlr_word_t tw;
    in_ch.valid = 1'b0; in_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.index = REG_DWIDTH; cfg_ch.wdata = '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tw = '0; tw.char_valid = 1; tw.char_byte = "A"; tw.line_length = 1;
    tw.win_width = 80; tw.win_height = 24;
    dir_tab.push_back('{"A", 1, tw});
    tw.char_byte = 8'd126; tw.line_length = 2;
    dir_tab.push_back('{8'd126, 1, tw});
    tw = '0; tw.event_res = EV_EC; tw.line_length = 1; tw.win_width = 80; tw.win_height = 24;
    dir_tab.push_back('{C_BS, 1, tw});
    begin
      logic [7:0] d[$] = '{C_DEL, C_DEL, 8'd32, C_CR, C_LF, C_LF, C_CR, 8'd0, 8'd128, 8'd31,
                           C_IAC, C_EL, C_IAC, C_IP, C_IAC, C_DO, C_ECHO, 8'd120,
                           C_IAC, C_WILL, C_TTYPE, C_IAC, C_DO, C_EORO, C_IAC, C_DONT,
                           C_EORO, C_IAC, C_IAC, 8'd255};
      foreach (d[i]) dir_tab.push_back('{d[i], 0, '0});
    end
    foreach (dir_tab[i]) send_byte(dir_tab[i].b, dir_tab[i].typed, dir_tab[i].w);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_DWIDTH, 16'd1); write_reg(REG_DLINES, 16'hFFFF);
          write_reg(REG_DGA, 16'd0); write_reg(REG_PWD, 16'd0);
        end
        1: begin
          write_reg(REG_DWIDTH, 16'hFFFF); write_reg(REG_DLINES, 16'd1);
          write_reg(REG_DGA, 16'd1); write_reg(REG_PWD, 16'd1);
        end
        default: begin
          write_reg(REG_DWIDTH, 16'($urandom_range(1, 65535)));
          write_reg(REG_DLINES, 16'($urandom_range(1, 65535)));
          write_reg(REG_DGA, 16'($urandom));
          write_reg(REG_PWD, 16'($urandom));
        end
      endcase
      cfg_ch.valid <= 1'b0;
      if (ph == 5) quiet = 1'b1;
      rx_bytes.delete();
      if (ph == 2) begin
        repeat (LINE_BUFFER_DEF + 2) rx_bytes.push_back(8'($urandom_range(32, 126)));
        rx_bytes.push_back(C_CR);
      end
      while (rx_bytes.size() < 30) gen_seq();
      foreach (rx_bytes[i]) send_byte(rx_bytes[i]);
      drain();
    end

    if (errors == 0 && exp_words.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/tlr_pkg.sv
hw/rtl/tlr_stream_if.sv
hw/rtl/tlr_cfg_if.sv
hw/rtl/tlr_front.sv
hw/rtl/tlr_queue.sv
hw/rtl/telnet_line_receiver_top.sv
tb/sv/tb_telnet_line_receiver_top.sv
